/* rtl/core/scpv_pkg.sv */
package scpv_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int RAD_W       = 31;
    localparam int COORD_W     = 32;
    localparam int MAG_W       = 33;
    localparam int RSUM_W      = 32;
    localparam int VERT_W      = 35;
    localparam int SQ_W        = 64;
    localparam int SUM_W       = 66;
    localparam int ROOT_STAGES = 32;
    localparam int ROOT_W      = 32;
    localparam int NUM_W       = 65;
    localparam int DEN_W       = 33;
    localparam int QUO_W       = 31;
    localparam int AXES        = 3;

    localparam logic [RAD_W-1:0] SELF_RADIUS_RESET = RAD_W'(64'd1 << FRAC_BITS);

    typedef struct packed {
        logic                      kind;
        logic signed [COORD_W-1:0] self_x;
        logic signed [COORD_W-1:0] self_y;
        logic signed [COORD_W-1:0] self_z;
        logic signed [COORD_W-1:0] other_x;
        logic signed [COORD_W-1:0] other_y;
        logic signed [COORD_W-1:0] other_z;
        logic        [RAD_W-1:0]   other_radius;
        logic        [RAD_W-1:0]   other_height;
    } t_req;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] push_x;
        logic signed [COORD_W-1:0] push_y;
        logic signed [COORD_W-1:0] push_z;
    } t_result;

    typedef struct packed {
        logic                            hit;
        logic                            kind;
        logic                            vhit;
        logic [AXES-1:0]                 neg;
        logic [AXES-1:0][MAG_W-1:0]      mag;
        logic [RSUM_W-1:0]               rsum;
        logic [VERT_W-1:0]               vmag;
        logic [COORD_W-1:0]              push_v;
    } t_side;

    typedef struct packed {
        logic               hit;
        logic               horiz;
        logic               len_zero;
        logic [AXES-1:0]    neg;
        logic [COORD_W-1:0] push_v;
    } t_tail;

endpackage

/* rtl/core/scpv_front.sv */
module scpv_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  scpv_pkg::t_req                i_req,
    input  logic [scpv_pkg::RAD_W-1:0]    i_self_radius,
    output logic                          o_valid,
    output scpv_pkg::t_side               o_side,
    output logic [scpv_pkg::SQ_W-1:0]     o_sum
);

    logic                                r_a_valid;
    logic                                r_a_kind;
    logic [scpv_pkg::AXES-1:0]           r_a_neg;
    logic [scpv_pkg::MAG_W-1:0]          r_a_mag [scpv_pkg::AXES];
    logic [scpv_pkg::RSUM_W-1:0]         r_a_rsum;
    logic [scpv_pkg::VERT_W-1:0]         r_a_up;
    logic [scpv_pkg::VERT_W-1:0]         r_a_down;

    logic                                n_a_neg_x, n_a_neg_y, n_a_neg_z;
    logic [scpv_pkg::MAG_W-1:0]          n_dx, n_dy, n_dz;
    logic [scpv_pkg::VERT_W-1:0]         n_sy, n_oy;

    logic                                r_b_valid;
    scpv_pkg::t_side                     r_b_side;
    logic [33:0]                         r_b_hh [scpv_pkg::AXES];
    logic [32:0]                         r_b_hl [scpv_pkg::AXES];
    logic [31:0]                         r_b_ll [scpv_pkg::AXES];
    logic [31:0]                         r_b_rhh, r_b_rhl, r_b_rll;
    scpv_pkg::t_side                     n_b_side;
    logic                                n_up_lt;
    logic [scpv_pkg::VERT_W-1:0]         n_half;

    logic                                r_c_valid;
    scpv_pkg::t_side                     r_c_side;
    logic [scpv_pkg::SQ_W-1:0]           r_c_sq [scpv_pkg::AXES];
    logic [scpv_pkg::SQ_W-1:0]           r_c_lim;

    logic                                r_d_valid;
    scpv_pkg::t_side                     r_d_side;
    logic [scpv_pkg::SUM_W-1:0]          r_d_sum;
    logic [scpv_pkg::SQ_W-1:0]           r_d_lim;

    logic                                r_e_valid;
    scpv_pkg::t_side                     r_e_side;
    logic [scpv_pkg::SQ_W-1:0]           r_e_sum;
    scpv_pkg::t_side                     n_e_side;

    always_comb begin
        n_dx = {i_req.self_x[31], i_req.self_x} - {i_req.other_x[31], i_req.other_x};
        n_dy = {i_req.self_y[31], i_req.self_y} - {i_req.other_y[31], i_req.other_y};
        n_dz = {i_req.self_z[31], i_req.self_z} - {i_req.other_z[31], i_req.other_z};
        n_a_neg_x = n_dx[32];
        n_a_neg_y = n_dy[32];
        n_a_neg_z = n_dz[32];
        n_sy = {{3{i_req.self_y[31]}}, i_req.self_y};
        n_oy = {{3{i_req.other_y[31]}}, i_req.other_y};
    end

    always_ff @(posedge i_clk) begin
        r_a_kind  <= i_req.kind;
        r_a_neg   <= {n_a_neg_z, n_a_neg_y, n_a_neg_x};
        r_a_mag[0] <= n_a_neg_x ? (33'd0 - n_dx) : n_dx;
        r_a_mag[1] <= i_req.kind ? 33'd0 : (n_a_neg_y ? (33'd0 - n_dy) : n_dy);
        r_a_mag[2] <= n_a_neg_z ? (33'd0 - n_dz) : n_dz;
        r_a_rsum  <= {1'b0, i_self_radius} + {1'b0, i_req.other_radius};
        r_a_up    <= n_sy + {4'd0, i_self_radius} - n_oy;
        r_a_down  <= n_oy + {4'd0, i_req.other_height} - n_sy + {4'd0, i_self_radius};
    end

    always_comb begin
        n_up_lt = $signed(r_a_up) < $signed(r_a_down);
        n_half  = n_up_lt ? (35'd0 - {1'b0, r_a_up[34:1]}) : {1'b0, r_a_down[34:1]};
        n_b_side        = '0;
        n_b_side.kind   = r_a_kind;
        n_b_side.vhit   = !r_a_up[34] && (r_a_up != '0) && !r_a_down[34] && (r_a_down != '0);
        n_b_side.neg    = r_a_neg;
        n_b_side.mag[0] = r_a_mag[0];
        n_b_side.mag[1] = r_a_mag[1];
        n_b_side.mag[2] = r_a_mag[2];
        n_b_side.rsum   = r_a_rsum;
        n_b_side.vmag   = n_up_lt ? r_a_up : r_a_down;
        if (n_half[34:31] == 4'b0000 || n_half[34:31] == 4'b1111) begin
            n_b_side.push_v = n_half[31:0];
        end else begin
            n_b_side.push_v = n_half[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_side <= n_b_side;
        for (int i = 0; i < scpv_pkg::AXES; i++) begin
            r_b_hh[i] <= 34'(r_a_mag[i][32:16]) * 34'(r_a_mag[i][32:16]);
            r_b_hl[i] <= 33'(r_a_mag[i][32:16]) * 33'(r_a_mag[i][15:0]);
            r_b_ll[i] <= 32'(r_a_mag[i][15:0]) * 32'(r_a_mag[i][15:0]);
        end
        r_b_rhh <= 32'(r_a_rsum[31:16]) * 32'(r_a_rsum[31:16]);
        r_b_rhl <= 32'(r_a_rsum[31:16]) * 32'(r_a_rsum[15:0]);
        r_b_rll <= 32'(r_a_rsum[15:0]) * 32'(r_a_rsum[15:0]);
    end

    always_ff @(posedge i_clk) begin
        r_c_side <= r_b_side;
        for (int i = 0; i < scpv_pkg::AXES; i++) begin
            r_c_sq[i] <= (64'(r_b_hh[i]) << 32) + (64'(r_b_hl[i]) << 17) + 64'(r_b_ll[i]);
        end
        r_c_lim <= (64'(r_b_rhh) << 32) + (64'(r_b_rhl) << 17) + 64'(r_b_rll);
    end

    always_ff @(posedge i_clk) begin
        r_d_side <= r_c_side;
        r_d_sum  <= 66'(r_c_sq[0]) + 66'(r_c_sq[1]) + 66'(r_c_sq[2]);
        r_d_lim  <= r_c_lim;
    end

    always_comb begin
        n_e_side     = r_d_side;
        n_e_side.hit = (r_d_sum < 66'(r_d_lim)) && (!r_d_side.kind || r_d_side.vhit);
    end

    always_ff @(posedge i_clk) begin
        r_e_side <= n_e_side;
        r_e_sum  <= r_d_sum[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
        end
    end

    assign o_valid = r_e_valid;
    assign o_side  = r_e_side;
    assign o_sum   = r_e_sum;

endmodule

/* rtl/core/scpv_sqrt.sv */
module scpv_sqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  scpv_pkg::t_side                i_side,
    input  logic [scpv_pkg::SQ_W-1:0]      i_value,
    output logic                           o_valid,
    output scpv_pkg::t_side                o_side,
    output logic [scpv_pkg::ROOT_W-1:0]    o_root
);

    logic                            r_valid [scpv_pkg::ROOT_STAGES];
    scpv_pkg::t_side                 r_side  [scpv_pkg::ROOT_STAGES];
    logic [scpv_pkg::SQ_W-1:0]       r_op    [scpv_pkg::ROOT_STAGES];
    logic [scpv_pkg::SQ_W-1:0]       r_res   [scpv_pkg::ROOT_STAGES];

    for (genvar k = 0; k < scpv_pkg::ROOT_STAGES; k++) begin : g_step
        localparam logic [scpv_pkg::SQ_W-1:0] BIT_K =
            scpv_pkg::SQ_W'(1) << (scpv_pkg::SQ_W - 2 - 2 * k);
        logic                      w_valid;
        scpv_pkg::t_side           w_side;
        logic [scpv_pkg::SQ_W-1:0] w_op;
        logic [scpv_pkg::SQ_W-1:0] w_res;
        logic [scpv_pkg::SQ_W-1:0] w_trial;

        if (k == 0) begin : g_head
            assign w_valid = i_valid;
            assign w_side  = i_side;
            assign w_op    = i_value;
            assign w_res   = '0;
        end else begin : g_body
            assign w_valid = r_valid[k-1];
            assign w_side  = r_side[k-1];
            assign w_op    = r_op[k-1];
            assign w_res   = r_res[k-1];
        end

        assign w_trial = w_res + BIT_K;

        always_ff @(posedge i_clk) begin
            r_side[k] <= w_side;
            if (w_op >= w_trial) begin
                r_op[k]  <= w_op - w_trial;
                r_res[k] <= (w_res >> 1) + BIT_K;
            end else begin
                r_op[k]  <= w_op;
                r_res[k] <= w_res >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= w_valid;
            end
        end
    end

    assign o_valid = r_valid[scpv_pkg::ROOT_STAGES-1];
    assign o_side  = r_side[scpv_pkg::ROOT_STAGES-1];
    assign o_root  = r_res[scpv_pkg::ROOT_STAGES-1][scpv_pkg::ROOT_W-1:0];

endmodule

/* rtl/core/scpv_div.sv */
module scpv_div (
    input  logic                         i_clk,
    input  logic [scpv_pkg::NUM_W-1:0]   i_num,
    input  logic [scpv_pkg::DEN_W-1:0]   i_den,
    output logic [scpv_pkg::QUO_W-1:0]   o_quo
);

    logic [scpv_pkg::NUM_W-1:0] r_rem [scpv_pkg::QUO_W];
    logic [scpv_pkg::DEN_W-1:0] r_den [scpv_pkg::QUO_W];
    logic [scpv_pkg::QUO_W-1:0] r_quo [scpv_pkg::QUO_W];

    for (genvar k = 0; k < scpv_pkg::QUO_W; k++) begin : g_step
        localparam int SHIFT = scpv_pkg::QUO_W - 1 - k;
        logic [scpv_pkg::NUM_W-1:0] w_rem;
        logic [scpv_pkg::DEN_W-1:0] w_den;
        logic [scpv_pkg::QUO_W-1:0] w_quo;
        logic [scpv_pkg::NUM_W-1:0] w_trial;

        if (k == 0) begin : g_head
            assign w_rem = i_num;
            assign w_den = i_den;
            assign w_quo = '0;
        end else begin : g_body
            assign w_rem = r_rem[k-1];
            assign w_den = r_den[k-1];
            assign w_quo = r_quo[k-1];
        end

        assign w_trial = scpv_pkg::NUM_W'(w_den) << SHIFT;

        always_ff @(posedge i_clk) begin
            r_den[k] <= w_den;
            if (w_rem >= w_trial) begin
                r_rem[k] <= w_rem - w_trial;
                r_quo[k] <= w_quo | (scpv_pkg::QUO_W'(1) << SHIFT);
            end else begin
                r_rem[k] <= w_rem;
                r_quo[k] <= w_quo;
            end
        end
    end

    assign o_quo = r_quo[scpv_pkg::QUO_W-1];

endmodule

/* rtl/core/scpv_push.sv */
module scpv_push (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  scpv_pkg::t_side                i_side,
    input  logic [scpv_pkg::ROOT_W-1:0]    i_root,
    output logic                           o_valid,
    output scpv_pkg::t_result              o_result
);

    logic [scpv_pkg::RSUM_W-1:0]  n_pen;
    scpv_pkg::t_tail              n_tail;

    logic                         r_p0_valid;
    scpv_pkg::t_tail              r_p0_tail;
    logic [scpv_pkg::RSUM_W-1:0]  r_p0_pen;
    logic [scpv_pkg::MAG_W-1:0]   r_p0_mag [scpv_pkg::AXES];
    logic [scpv_pkg::DEN_W-1:0]   r_p0_den;

    logic                         r_p1_valid;
    scpv_pkg::t_tail              r_p1_tail;
    logic [32:0]                  r_p1_hh [scpv_pkg::AXES];
    logic [32:0]                  r_p1_hl [scpv_pkg::AXES];
    logic [31:0]                  r_p1_lh [scpv_pkg::AXES];
    logic [31:0]                  r_p1_ll [scpv_pkg::AXES];
    logic [scpv_pkg::DEN_W-1:0]   r_p1_den;

    logic                         r_p2_valid;
    scpv_pkg::t_tail              r_p2_tail;
    logic [scpv_pkg::NUM_W-1:0]   r_p2_num [scpv_pkg::AXES];
    logic [scpv_pkg::DEN_W-1:0]   r_p2_den;

    logic [scpv_pkg::QUO_W-1:0]   w_quo [scpv_pkg::AXES];
    logic                         r_dl_valid [scpv_pkg::QUO_W];
    scpv_pkg::t_tail              r_dl_tail  [scpv_pkg::QUO_W];

    scpv_pkg::t_tail              w_last;
    logic [scpv_pkg::COORD_W-1:0] n_comp [scpv_pkg::AXES];
    scpv_pkg::t_result            n_result;
    logic                         r_out_valid;
    scpv_pkg::t_result            r_out_result;

    always_comb begin
        n_pen           = i_side.rsum - i_root;
        n_tail.hit      = i_side.hit;
        n_tail.horiz    = !i_side.kind || ($signed({3'b000, n_pen}) < $signed(i_side.vmag));
        n_tail.len_zero = (i_root == '0);
        n_tail.neg      = i_side.neg;
        n_tail.push_v   = i_side.push_v;
    end

    always_ff @(posedge i_clk) begin
        r_p0_tail <= n_tail;
        r_p0_pen  <= n_pen;
        r_p0_den  <= {i_root, 1'b0};
        for (int i = 0; i < scpv_pkg::AXES; i++) begin
            r_p0_mag[i] <= i_side.mag[i];
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_tail <= r_p0_tail;
        r_p1_den  <= r_p0_den;
        for (int i = 0; i < scpv_pkg::AXES; i++) begin
            r_p1_hh[i] <= 33'(r_p0_mag[i][32:16]) * 33'(r_p0_pen[31:16]);
            r_p1_hl[i] <= 33'(r_p0_mag[i][32:16]) * 33'(r_p0_pen[15:0]);
            r_p1_lh[i] <= 32'(r_p0_mag[i][15:0]) * 32'(r_p0_pen[31:16]);
            r_p1_ll[i] <= 32'(r_p0_mag[i][15:0]) * 32'(r_p0_pen[15:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_p2_tail <= r_p1_tail;
        r_p2_den  <= r_p1_den;
        for (int i = 0; i < scpv_pkg::AXES; i++) begin
            r_p2_num[i] <= (65'(r_p1_hh[i]) << 32)
                         + ((65'(r_p1_hl[i]) + 65'(r_p1_lh[i])) << 16)
                         + 65'(r_p1_ll[i]);
        end
    end

    for (genvar a = 0; a < scpv_pkg::AXES; a++) begin : g_axis
        scpv_div u_div (
            .i_clk (i_clk),
            .i_num (r_p2_num[a]),
            .i_den (r_p2_den),
            .o_quo (w_quo[a])
        );
    end

    always_ff @(posedge i_clk) begin
        r_dl_tail[0] <= r_p2_tail;
        for (int k = 1; k < scpv_pkg::QUO_W; k++) begin
            r_dl_tail[k] <= r_dl_tail[k-1];
        end
    end

    assign w_last = r_dl_tail[scpv_pkg::QUO_W-1];

    always_comb begin
        for (int i = 0; i < scpv_pkg::AXES; i++) begin
            n_comp[i] = w_last.neg[i] ? (32'd0 - {1'b0, w_quo[i]}) : {1'b0, w_quo[i]};
        end
        n_result = '0;
        if (w_last.hit) begin
            n_result.hit = 1'b1;
            if (w_last.horiz) begin
                if (!w_last.len_zero) begin
                    n_result.push_x = n_comp[0];
                    n_result.push_y = n_comp[1];
                    n_result.push_z = n_comp[2];
                end
            end else begin
                n_result.push_y = w_last.push_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_valid  <= 1'b0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < scpv_pkg::QUO_W; k++) begin
                r_dl_valid[k] <= 1'b0;
            end
        end else begin
            r_p0_valid    <= i_valid;
            r_p1_valid    <= r_p0_valid;
            r_p2_valid    <= r_p1_valid;
            r_dl_valid[0] <= r_p2_valid;
            for (int k = 1; k < scpv_pkg::QUO_W; k++) begin
                r_dl_valid[k] <= r_dl_valid[k-1];
            end
            r_out_valid <= r_dl_valid[scpv_pkg::QUO_W-1];
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out_result;

endmodule

/* rtl/core/sphere_collision_push_vector.sv */
// Fully pipelined sphere/cylinder test that takes one request in every cycle, so busy stays low; each
// result passes through the one-bit-per-stage square root (32 stages) and divider (31 stages)
// plus nine stages of squaring, scaling and selection, and is shown for a single cycle on
// o_done, which the receiver cannot stall.
module sphere_collision_push_vector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  scpv_pkg::t_req                i_req,
    output logic                          o_done,
    output scpv_pkg::t_result             o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [scpv_pkg::RAD_W-1:0]    i_cfg_data
);

    logic [scpv_pkg::RAD_W-1:0]   r_self_radius;
    logic                         w_front_valid;
    scpv_pkg::t_side              w_front_side;
    logic [scpv_pkg::SQ_W-1:0]    w_front_sum;
    logic                         w_root_valid;
    scpv_pkg::t_side              w_root_side;
    logic [scpv_pkg::ROOT_W-1:0]  w_root;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_radius <= scpv_pkg::SELF_RADIUS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_self_radius <= i_cfg_data;
        end
    end

    scpv_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (start && !busy),
        .i_req         (i_req),
        .i_self_radius (r_self_radius),
        .o_valid       (w_front_valid),
        .o_side        (w_front_side),
        .o_sum         (w_front_sum)
    );

    scpv_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_valid),
        .i_side  (w_front_side),
        .i_value (w_front_sum),
        .o_valid (w_root_valid),
        .o_side  (w_root_side),
        .o_root  (w_root)
    );

    scpv_push u_push (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_root_valid),
        .i_side   (w_root_side),
        .i_root   (w_root),
        .o_valid  (o_done),
        .o_result (o_result)
    );

endmodule
